// ===== rtl/core/uart_register_frame_master_defines.svh =====
`ifndef UART_REGISTER_FRAME_MASTER_DEFINES_SVH
`define UART_REGISTER_FRAME_MASTER_DEFINES_SVH

// Assertions sample on clk and stay off while rst_n is low.
`ifndef SYNTH
`define URFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define URFM_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define URFM_ASSERT(label, prop, msg)
`define URFM_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

// ===== rtl/core/urfm_pkg.sv =====
package urfm_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFE;
    localparam logic [7:0] READ_FLAG = 8'h80;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRITE_ACK = 3'd1;
    localparam logic [2:0] ST_TMO_MSB   = 3'd2;
    localparam logic [2:0] ST_TMO_LSB   = 3'd3;
    localparam logic [2:0] ST_TMO_CHECK = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;

    localparam int MAX_RESULTS = 5;

    typedef struct packed {
        logic [2:0]                   count;
        logic                         done;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        logic [2:0]                   status;
        logic [15:0]                  read_data;
    } urfm_frame_t;

endpackage

// ===== rtl/core/urfm_core.sv =====
module urfm_core import urfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        mode,
    input  logic [6:0]        reg_address,
    input  logic [15:0]       write_value,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       timeout_ticks,
    output urfm_frame_t       frame
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_ACK   = 3'd1;
    localparam logic [2:0] PH_READ_MSB   = 3'd2;
    localparam logic [2:0] PH_READ_LSB   = 3'd3;
    localparam logic [2:0] PH_READ_CHECK = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  expected_check_reg, expected_check_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [15:0] wait_count_reg, wait_count_next;

    logic [7:0]  addr_byte;
    logic [7:0]  read_addr;
    logic [7:0]  write_check;
    logic [7:0]  read_sum;
    logic [15:0] wait_inc;

    assign addr_byte   = {1'b0, reg_address};
    assign read_addr   = addr_byte | READ_FLAG;
    assign write_check = write_value[15:8] + write_value[7:0] + addr_byte;
    assign read_sum    = high_byte_reg + low_byte_reg;
    assign wait_inc    = (wait_count_reg == 16'hFFFF) ? wait_count_reg
                                                      : wait_count_reg + 16'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        expected_check_next = expected_check_reg;
        high_byte_next      = high_byte_reg;
        low_byte_next       = low_byte_reg;
        wait_count_next     = wait_count_reg;
        frame               = '0;
        case (mode)
            MODE_WRITE, MODE_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    wait_count_next = '0;
                    if (mode == MODE_WRITE)
                    begin
                        frame.count         = 3'd5;
                        frame.bytes         = {write_check, write_value[7:0],
                                               write_value[15:8], addr_byte, SYNC_BYTE};
                        expected_check_next = write_check;
                        phase_next          = PH_WAIT_ACK;
                    end
                    else
                    begin
                        frame.count         = 3'd3;
                        frame.bytes         = {8'd0, 8'd0, read_addr, read_addr, SYNC_BYTE};
                        expected_check_next = read_addr;
                        phase_next          = PH_READ_MSB;
                    end
                end
            end
            MODE_RX:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    wait_count_next = '0;
                    case (phase_reg)
                        PH_WAIT_ACK:
                        begin
                            frame.count  = 3'd1;
                            frame.done   = 1'b1;
                            frame.status = (rx_byte == expected_check_reg) ? ST_OK
                                                                           : ST_WRITE_ACK;
                            phase_next   = PH_IDLE;
                        end
                        PH_READ_MSB:
                        begin
                            high_byte_next = rx_byte;
                            phase_next     = PH_READ_LSB;
                        end
                        PH_READ_LSB:
                        begin
                            low_byte_next = rx_byte;
                            phase_next    = PH_READ_CHECK;
                        end
                        default:
                        begin
                            frame.count = 3'd1;
                            frame.done  = 1'b1;
                            if (read_sum == rx_byte)
                            begin
                                frame.status    = ST_OK;
                                frame.read_data = {high_byte_reg, low_byte_reg};
                            end
                            else
                            begin
                                frame.status = ST_CHECKSUM;
                            end
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    wait_count_next = wait_inc;
                    if (wait_inc >= timeout_ticks)
                    begin
                        frame.count     = 3'd1;
                        frame.done      = 1'b1;
                        phase_next      = PH_IDLE;
                        wait_count_next = '0;
                        case (phase_reg)
                            PH_WAIT_ACK: frame.status = ST_WRITE_ACK;
                            PH_READ_MSB: frame.status = ST_TMO_MSB;
                            PH_READ_LSB: frame.status = ST_TMO_LSB;
                            default:     frame.status = ST_TMO_CHECK;
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            expected_check_reg <= '0;
            high_byte_reg      <= '0;
            low_byte_reg       <= '0;
            wait_count_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            expected_check_reg <= expected_check_next;
            high_byte_reg      <= high_byte_next;
            low_byte_reg       <= low_byte_next;
            wait_count_reg     <= wait_count_next;
        end
    end

endmodule

// ===== rtl/core/urfm_emit.sv =====
`include "uart_register_frame_master_defines.svh"

module urfm_emit import urfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  urfm_frame_t       frame_in,
    output logic              load_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic [2:0]                  count_reg, count_next;
    logic                        done_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [2:0]                  status_reg;
    logic [15:0]                 read_data_reg;
    logic                        pop;

    assign m_tvalid   = (count_reg != 3'd0);
    assign pop        = m_tvalid && m_tready;
    assign m_tlast    = (count_reg == 3'd1);
    assign m_tuser    = done_reg;
    assign m_tdata    = {5'd0, read_data_reg, status_reg, bytes_reg[0]};
    assign load_ready = !m_tvalid || (pop && m_tlast);

    always_comb
    begin
        count_next = count_reg;
        if (load)
            count_next = frame_in.count;
        else if (pop)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // shift the next byte to transfer into the low slot
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            done_reg      <= frame_in.done;
            bytes_reg     <= frame_in.bytes;
            status_reg    <= frame_in.status;
            read_data_reg <= frame_in.read_data;
        end
        else if (pop)
        begin
            bytes_reg <= {8'd0, bytes_reg[MAX_RESULTS-1:1]};
        end
    end

    `URFM_ASSERT(a_count_range, count_reg <= 3'd5, "result count out of range")
    `URFM_ASSERT(a_load_free, !load || count_reg == 3'd0 || (count_reg == 3'd1 && m_tready), "frame loaded over pending results")
    `URFM_ASSERT(a_done_single, !(m_tvalid && done_reg) || count_reg == 3'd1, "completion not a single result")
    `URFM_ASSERT_NEXT(a_pop_step, pop && !load && count_reg > 3'd1, count_reg == $past(count_reg) - 3'd1, "result count did not advance")

endmodule

// ===== rtl/core/uart_register_frame_master.sv =====
// Register-access frame engine for a serial link. Each transfer on the s_ side is one event:
// start write, start read, a received byte or a timer tick. A start emits its frame bytes
// on the m_ side (five for a write, three for a read, tuser 0, tlast on the final byte), and a
// finished transaction emits one completion (tuser 1) with status and read data. Events are
// accepted one per cycle while no results are pending; an event that yields N results holds
// s_tready low until N results have been transferred, released in the cycle the last one goes,
// as the output side holds a single frame. Starts while busy and bytes or ticks while idle
// produce nothing. timeout_ticks (cfg_wdata, reset 5) may be written at any time.
module uart_register_frame_master import urfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // reg_address[6:0], write_value[22:7], rx_byte[30:23], 0
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], status[10:8], read_data[26:11], 0
    output logic        m_tlast,
    output logic        m_tuser    // kind[0]
);

    logic [15:0] timeout_reg;
    logic        accept;
    urfm_frame_t frame;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= 16'd5;
        else if (cfg_we)
            timeout_reg <= cfg_wdata;
    end

    urfm_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mode          (s_tuser),
        .reg_address   (s_tdata[6:0]),
        .write_value   (s_tdata[22:7]),
        .rx_byte       (s_tdata[30:23]),
        .timeout_ticks (timeout_reg),
        .frame         (frame)
    );

    urfm_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .frame_in   (frame),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== sim/uart_register_frame_master_tb.sv =====
`timescale 1ns / 1ps

module uart_register_frame_master_tb;
    import urfm_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_WAIT_ACK,
        LINK_MSB,
        LINK_LSB,
        LINK_CHECK
    } link_state_e;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  addr;
        logic [15:0] value;
        logic [7:0]  rx;
    } link_req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  status;
        logic [15:0] read_data;
    } link_result_t;

    typedef struct packed {
        logic        cfg;
        logic        typed;
        logic [2:0]  n;
        logic [1:0]  mode;
        logic [6:0]  addr;
        logic [15:0] value;
        logic [7:0]  rx;
        logic [39:0] frame;
        logic [2:0]  status;
        logic [15:0] data;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    link_state_e  link_state;
    logic [7:0]   ack_byte;
    logic [7:0]   msb_byte;
    logic [7:0]   lsb_byte;
    logic [15:0]  tick_count;
    logic [15:0]  tmo_limit;

    link_result_t link_results [$];
    step_row_t    script [$];
    int           mismatches;
    int           src_idle_pct;
    int           snk_stall_pct;
    int           rx_hold_cycles;

    uart_register_frame_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic step_row_t row(input logic cfg, input logic typed, input logic [2:0] n,
                                      input logic [1:0] mode, input logic [6:0] addr,
                                      input logic [15:0] value, input logic [7:0] rx,
                                      input logic [39:0] frame, input logic [2:0] status,
                                      input logic [15:0] data);
        step_row_t r;
        r = '{cfg, typed, n, mode, addr, value, rx, frame, status, data};
        return r;
    endfunction

    function automatic void push_tx(input logic [7:0] b, input logic last, input bit record);
        link_result_t res;
        res = '{1'b0, b, last, ST_OK, 16'h0000};
        if (record)
            link_results.push_back(res);
    endfunction

    function automatic void finish_link(input logic [2:0] status, input logic [15:0] data,
                                        input bit record);
        link_result_t res;
        res = '{1'b1, 8'h00, 1'b1, status, data};
        if (record)
            link_results.push_back(res);
        link_state = LINK_IDLE;
        tick_count = '0;
    endfunction

    // Returns 0 when the request is dropped by the block.
    function automatic bit advance_link(input link_req_t r, input bit record);
        logic [7:0] chk;
        logic [7:0] hdr;
        logic [7:0] sum8;
        if (r.mode == MODE_WRITE || r.mode == MODE_READ)
        begin
            if (link_state != LINK_IDLE)
                return 1'b0;
            tick_count = '0;
            if (r.mode == MODE_WRITE)
            begin
                chk = r.value[15:8] + r.value[7:0] + {1'b0, r.addr};
                push_tx(SYNC_BYTE, 1'b0, record);
                push_tx({1'b0, r.addr}, 1'b0, record);
                push_tx(r.value[15:8], 1'b0, record);
                push_tx(r.value[7:0], 1'b0, record);
                push_tx(chk, 1'b1, record);
                ack_byte = chk;
                link_state = LINK_WAIT_ACK;
            end
            else
            begin
                hdr = {1'b0, r.addr} | READ_FLAG;
                push_tx(SYNC_BYTE, 1'b0, record);
                push_tx(hdr, 1'b0, record);
                push_tx(hdr, 1'b1, record);
                ack_byte = hdr;
                link_state = LINK_MSB;
            end
            return 1'b1;
        end
        if (link_state == LINK_IDLE)
            return 1'b0;
        if (r.mode == MODE_RX)
        begin
            tick_count = '0;
            case (link_state)
                LINK_WAIT_ACK:
                    finish_link((r.rx == ack_byte) ? ST_OK : ST_WRITE_ACK, 16'h0000, record);
                LINK_MSB:
                begin
                    msb_byte = r.rx;
                    link_state = LINK_LSB;
                end
                LINK_LSB:
                begin
                    lsb_byte = r.rx;
                    link_state = LINK_CHECK;
                end
                default:
                begin
                    sum8 = msb_byte + lsb_byte;
                    if (sum8 == r.rx)
                        finish_link(ST_OK, {msb_byte, lsb_byte}, record);
                    else
                        finish_link(ST_CHECKSUM, 16'h0000, record);
                end
            endcase
            return 1'b1;
        end
        if (tick_count != 16'hFFFF)
            tick_count = tick_count + 16'd1;
        if (tick_count >= tmo_limit)
        begin
            case (link_state)
                LINK_WAIT_ACK: finish_link(ST_WRITE_ACK, 16'h0000, record);
                LINK_MSB:      finish_link(ST_TMO_MSB, 16'h0000, record);
                LINK_LSB:      finish_link(ST_TMO_LSB, 16'h0000, record);
                default:       finish_link(ST_TMO_CHECK, 16'h0000, record);
            endcase
        end
        return 1'b1;
    endfunction

    // Mostly well-formed exchanges, with wrong bytes, ticks and stray starts mixed in.
    function automatic link_req_t pick_request();
        link_req_t r;
        int        roll;
        logic [7:0] sum8;
        r.addr  = 7'($urandom_range(127));
        r.value = 16'($urandom_range(65535));
        r.rx    = 8'($urandom_range(255));
        roll    = $urandom_range(99);
        sum8    = msb_byte + lsb_byte;
        case (link_state)
            LINK_IDLE:
                r.mode = (roll < 46) ? MODE_WRITE : (roll < 92) ? MODE_READ
                                                                : 2'($urandom_range(3));
            LINK_WAIT_ACK:
            begin
                r.mode = (roll < 80) ? MODE_RX : (roll < 95) ? MODE_TICK
                                                             : 2'($urandom_range(1));
                if (roll < 70)
                    r.rx = ack_byte;
            end
            LINK_MSB, LINK_LSB:
                r.mode = (roll < 70) ? MODE_RX : (roll < 95) ? MODE_TICK
                                                             : 2'($urandom_range(1));
            default:
            begin
                r.mode = (roll < 80) ? MODE_RX : (roll < 95) ? MODE_TICK
                                                             : 2'($urandom_range(1));
                if (roll < 65)
                    r.rx = sum8;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input link_req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {1'b0, r.rx, r.value, r.addr};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        s_tvalid <= 1'b0;
        while (link_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tmo_limit = ticks;
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
        link_req_t r;
        int        taken;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        taken = 0;
        while (taken < n_items)
        begin
            r = pick_request();
            send_request(r);
            if (advance_link(r, 1'b1))
                taken++;
        end
    endtask

    task automatic check_result();
        link_result_t want;
        if (link_results.size() == 0)
        begin
            $error("unexpected transfer: tuser %0b tdata %h tlast %0b", m_tuser, m_tdata, m_tlast);
            mismatches++;
            return;
        end
        want = link_results.pop_front();
        if (m_tuser !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            mismatches++;
        end
        if (m_tdata[7:0] !== want.tx_byte)
        begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, m_tdata[7:0]);
            mismatches++;
        end
        if (m_tlast !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            mismatches++;
        end
        if (m_tdata[10:8] !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[10:8]);
            mismatches++;
        end
        if (m_tdata[26:11] !== want.read_data)
        begin
            $error("read_data: expected %h, got %h", want.read_data, m_tdata[26:11]);
            mismatches++;
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result();
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles = rx_hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        link_req_t r;
        link_result_t res;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_WRITE;
        mismatches     = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        rx_hold_cycles = 0;
        link_state = LINK_IDLE;
        ack_byte   = '0;
        msb_byte   = '0;
        lsb_byte   = '0;
        tick_count = '0;
        tmo_limit  = 16'd5;

        script = '{
            // cfg typ n  mode        addr   value     rx     frame               status
            row(0, 1, 0, MODE_RX,    7'h00, 16'h0000, 8'hFF, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 0, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 5, MODE_WRITE, 7'h00, 16'h0000, 8'h00, 40'hFE_00_00_00_00, ST_OK,
                16'h0000),
            row(0, 1, 0, MODE_READ,  7'h7F, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_RX,    7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 5, MODE_WRITE, 7'h7F, 16'hFFFF, 8'h00, 40'hFE_7F_FF_FF_7D, ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_RX,    7'h00, 16'h0000, 8'h7C, 40'h0,              ST_WRITE_ACK,
                16'h0000),
            row(0, 1, 3, MODE_READ,  7'h7F, 16'h0000, 8'h00, 40'hFE_FF_FF_00_00, ST_OK,
                16'h0000),
            row(0, 1, 0, MODE_RX,    7'h00, 16'h0000, 8'hFF, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 0, MODE_RX,    7'h00, 16'h0000, 8'hFF, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_RX,    7'h00, 16'h0000, 8'hFE, 40'h0,              ST_OK,
                16'hFFFF),
            row(0, 1, 3, MODE_READ,  7'h00, 16'hFFFF, 8'h00, 40'hFE_80_80_00_00, ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_TMO_MSB,
                16'h0000),
            row(0, 0, 0, MODE_READ,  7'h2A, 16'hA5C3, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_RX,    7'h00, 16'h0000, 8'h12, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_RX,    7'h00, 16'h0000, 8'h34, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_RX,    7'h00, 16'h0000, 8'h00, 40'h0,              ST_CHECKSUM,
                16'h0000),
            row(1, 0, 0, MODE_TICK,  7'h00, 16'd1,    8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_READ,  7'h55, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_RX,    7'h00, 16'h0000, 8'h9C, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_TMO_LSB,
                16'h0000),
            row(0, 0, 0, MODE_READ,  7'h01, 16'h0000, 8'h00, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_RX,    7'h00, 16'h0000, 8'h01, 40'h0,              ST_OK,
                16'h0000),
            row(0, 0, 0, MODE_RX,    7'h00, 16'h0000, 8'h02, 40'h0,              ST_OK,
                16'h0000),
            row(0, 1, 1, MODE_TICK,  7'h00, 16'h0000, 8'h00, 40'h0,              ST_TMO_CHECK,
                16'h0000)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].cfg)
                set_timeout(script[i].value);
            else
            begin
                r = '{script[i].mode, script[i].addr, script[i].value, script[i].rx};
                send_request(r);
                void'(advance_link(r, !script[i].typed));
                if (script[i].typed)
                begin
                    if (script[i].mode == MODE_RX || script[i].mode == MODE_TICK)
                    begin
                        if (script[i].n != 0)
                        begin
                            res = '{1'b1, 8'h00, 1'b1, script[i].status, script[i].data};
                            link_results.push_back(res);
                        end
                    end
                    else
                    begin
                        for (int k = 0; k < script[i].n; k++)
                        begin
                            res = '{1'b0, script[i].frame[39 - 8 * k -: 8],
                                    k == script[i].n - 1, ST_OK, 16'h0000};
                            link_results.push_back(res);
                        end
                    end
                end
            end
        end

        set_timeout(16'd1);
        run_phase(0, 0, 20);
        set_timeout(16'hFFFF);
        run_phase(70, 0, 20);
        set_timeout(16'd3);
        run_phase(0, 70, 20);
        set_timeout(16'($urandom_range(8, 2)));
        run_phase(32, 32, 20);
        set_timeout(16'd2);
        // hold the output side off so the block backs up into its input
        rx_hold_cycles = 300;
        run_phase(0, 0, 20);

        s_tvalid <= 1'b0;
        while (link_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
